// ===== rtl/core/tas_pkg.sv =====
// ----------------------------------------------------------------------------
// Trajectory arc scorer package
// Shared payload types, register indexes, state encodings and the arctangent
// table for the arc scorer core.
// ----------------------------------------------------------------------------
package tas_pkg;

  localparam int COORD_W   = 24;
  localparam int SCORE_W   = 17;
  localparam int ARC_W     = 8;
  localparam int CFG_IDX_W = 4;
  localparam int ANG_W     = 26;
  localparam int TERM_W    = 17;

  localparam logic [ANG_W-1:0] DEG90  = 26'd5898240;
  localparam logic [ANG_W-1:0] DEG180 = 26'd11796480;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GOAL_DIVISOR = 4'd0,
    CFG_GOAL_COUNT   = 4'd1,
    CFG_GOAL0_X      = 4'd2,
    CFG_GOAL0_Y      = 4'd3,
    CFG_GOAL1_X      = 4'd4,
    CFG_GOAL1_Y      = 4'd5,
    CFG_GOAL2_X      = 4'd6,
    CFG_GOAL2_Y      = 4'd7
  } cfg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] waypoint_x;
    logic signed [COORD_W-1:0] waypoint_y;
    logic                      waypoint_blocked;
    logic                      arc_end;
    logic                      batch_start;
  } in_t;

  typedef struct packed {
    logic [ARC_W-1:0]   arc_number;
    logic               arc_feasible;
    logic [SCORE_W-1:0] arc_score;
    logic               best_valid;
    logic [ARC_W-1:0]   best_arc;
    logic [SCORE_W-1:0] lead_score;
  } out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WAIT,
    S_DIV,
    S_OUT
  } core_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL,
    U_NORM,
    U_ROT,
    U_DIV,
    U_SQRT,
    U_DONE
  } unit_state_t;

  // Arctangent of 2^-i in degrees, Q.16.
  function automatic logic [ANG_W-1:0] atan_q16(input logic [4:0] i);
    logic [ANG_W-1:0] v;
    case (i)
      5'd0:  v = 26'd2949120;
      5'd1:  v = 26'd1740967;
      5'd2:  v = 26'd919879;
      5'd3:  v = 26'd466945;
      5'd4:  v = 26'd234379;
      5'd5:  v = 26'd117304;
      5'd6:  v = 26'd58666;
      5'd7:  v = 26'd29335;
      5'd8:  v = 26'd14668;
      5'd9:  v = 26'd7334;
      5'd10: v = 26'd3667;
      5'd11: v = 26'd1833;
      5'd12: v = 26'd917;
      5'd13: v = 26'd458;
      5'd14: v = 26'd229;
      5'd15: v = 26'd115;
      5'd16: v = 26'd57;
      5'd17: v = 26'd29;
      5'd18: v = 26'd14;
      5'd19: v = 26'd7;
      5'd20: v = 26'd4;
      5'd21: v = 26'd2;
      5'd22: v = 26'd1;
      5'd23: v = 26'd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/trajectory_arc_scorer_core.sv =====
// ----------------------------------------------------------------------------
// Trajectory arc scorer core
// Scores candidate arcs against up to three goal directions and keeps the
// best feasible arc of the batch.
// ----------------------------------------------------------------------------
// Usage: waypoints arrive on the in_ channel as requests, one per cycle while
// the core is idle. A waypoint that does not end an arc updates only the
// feasibility flag of the current arc and, on a batch start, the batch tracking.
// A waypoint that ends an arc starts scoring. Each used goal runs through the
// goal unit: a start state, a serial dot and cross product, normalization,
// 24 CORDIC steps, a serial divide, a serial root and a done state; when
// either vector is zero the unit goes straight to the divide. The goal sum
// is then averaged in a serial divide and the result is loaded into the
// output register. An arc that is infeasible or uses no goal skips the goal
// unit and the divide. Each arc end yields one request on the out_ channel,
// held in an output register; further waypoints are accepted while it waits,
// and the next arc end waits for it to be taken. Reset clears the batch
// tracking, sets the divisor register to 3 and the goals to zero. The cfg_
// port is always ready.
// ----------------------------------------------------------------------------
module trajectory_arc_scorer_core #(
  parameter int MAX_ARCS  = 256,
  parameter int MAX_GOALS = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  tas_pkg::in_t                         in_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output tas_pkg::out_t                        out_data,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [tas_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [tas_pkg::COORD_W-1:0]          cfg_data
);

  localparam int ARC_LIMIT_I = (MAX_ARCS < 256 ? MAX_ARCS : 256) - 1;
  localparam logic [tas_pkg::ARC_W-1:0] ARC_LIMIT = tas_pkg::ARC_W'(ARC_LIMIT_I);
  localparam logic [1:0] GOAL_CAP = 2'(MAX_GOALS);
  localparam int SUM_W = 18;

  tas_pkg::core_state_t state_r, state_nxt;

  logic [1:0]                         gtu_r, gcnt_r;
  logic signed [tas_pkg::COORD_W-1:0] goal_x_r [3];
  logic signed [tas_pkg::COORD_W-1:0] goal_y_r [3];

  logic signed [tas_pkg::COORD_W-1:0] ex_r, ex_nxt, ey_r, ey_nxt;
  logic                        feas_r, feas_nxt;
  logic [1:0]                  g_r, g_nxt, m_r, m_nxt, rem_r, rem_nxt;
  logic [SUM_W-1:0]            sum_r, sum_nxt;
  logic [4:0]                  cnt_r, cnt_nxt;
  logic                        arc_clear_r, arc_clear_nxt;
  logic [tas_pkg::ARC_W-1:0]   arc_cnt_r, arc_cnt_nxt, best_arc_r, best_arc_nxt;
  logic [tas_pkg::SCORE_W-1:0] best_val_r, best_val_nxt;
  logic                        best_seen_r, best_seen_nxt;
  logic                        out_valid_r, out_valid_nxt;
  tas_pkg::out_t               out_r, out_nxt;

  logic       in_acc, out_free, unit_start, unit_done, take_best;
  logic [1:0] m_goals;
  logic [2:0] r3;
  logic       clear_now;
  logic [tas_pkg::TERM_W-1:0] unit_term;

  assign in_ready  = (state_r == tas_pkg::S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Goals actually used: the smallest of the divisor, goal_count and the cap.
  always_comb begin
    m_goals = (gtu_r < gcnt_r) ? gtu_r : gcnt_r;
    if (m_goals > GOAL_CAP) m_goals = GOAL_CAP;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gtu_r  <= 2'd3;
      gcnt_r <= 2'd0;
      for (int i = 0; i < 3; i++) begin
        goal_x_r[i] <= '0;
        goal_y_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tas_pkg::CFG_GOAL_DIVISOR: gtu_r <= cfg_data[1:0];
        tas_pkg::CFG_GOAL_COUNT:   gcnt_r <= cfg_data[1:0];
        tas_pkg::CFG_GOAL0_X:      goal_x_r[0] <= cfg_data;
        tas_pkg::CFG_GOAL0_Y:      goal_y_r[0] <= cfg_data;
        tas_pkg::CFG_GOAL1_X:      goal_x_r[1] <= cfg_data;
        tas_pkg::CFG_GOAL1_Y:      goal_y_r[1] <= cfg_data;
        tas_pkg::CFG_GOAL2_X:      goal_x_r[2] <= cfg_data;
        tas_pkg::CFG_GOAL2_Y:      goal_y_r[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  tas_goal_unit u_goal (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .ex    (ex_r),
    .ey    (ey_r),
    .gx    (goal_x_r[g_r]),
    .gy    (goal_y_r[g_r]),
    .done  (unit_done),
    .term  (unit_term)
  );

  // A batch start resets the feasibility flag to feasible before this waypoint counts.
  assign clear_now = (in_data.batch_start || arc_clear_r) && !in_data.waypoint_blocked;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tas_pkg::S_IDLE: begin
        if (in_acc && in_data.arc_end) begin
          state_nxt = (clear_now && m_goals != 2'd0) ? tas_pkg::S_START : tas_pkg::S_OUT;
        end
      end
      tas_pkg::S_START: state_nxt = tas_pkg::S_WAIT;
      tas_pkg::S_WAIT: begin
        if (unit_done) begin
          state_nxt = (g_r + 2'd1 == m_r) ? tas_pkg::S_DIV : tas_pkg::S_START;
        end
      end
      tas_pkg::S_DIV:   if (cnt_r == 5'(SUM_W - 1)) state_nxt = tas_pkg::S_OUT;
      tas_pkg::S_OUT:   if (out_free) state_nxt = tas_pkg::S_IDLE;
      default:          state_nxt = tas_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    unit_start = (state_r == tas_pkg::S_START);
  end

  always_comb begin
    ex_nxt = ex_r;  ey_nxt = ey_r;  feas_nxt = feas_r;  g_nxt = g_r;  m_nxt = m_r;
    sum_nxt = sum_r;  cnt_nxt = cnt_r;  rem_nxt = rem_r;
    arc_clear_nxt = arc_clear_r;  arc_cnt_nxt = arc_cnt_r;
    best_arc_nxt = best_arc_r;  best_val_nxt = best_val_r;  best_seen_nxt = best_seen_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt = out_r;
    r3 = {rem_r, sum_r[SUM_W-1]};
    take_best = feas_r && (!best_seen_r || sum_r[tas_pkg::SCORE_W-1:0] > best_val_r);
    unique case (state_r)
      tas_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_data.batch_start) begin
            arc_cnt_nxt = '0;
            best_seen_nxt = 1'b0;
            best_val_nxt = '0;
            best_arc_nxt = '0;
          end
          arc_clear_nxt = in_data.arc_end ? 1'b1 : clear_now;
          ex_nxt = in_data.waypoint_x;
          ey_nxt = in_data.waypoint_y;
          feas_nxt = clear_now;
          g_nxt = '0;
          m_nxt = m_goals;
          sum_nxt = '0;
          cnt_nxt = '0;
          rem_nxt = '0;
        end
      end
      tas_pkg::S_WAIT: begin
        if (unit_done) begin
          sum_nxt = sum_r + SUM_W'(unit_term);
          g_nxt = g_r + 2'd1;
        end
      end
      tas_pkg::S_DIV: begin
        // Serial restoring divide of the goal sum by the divisor register.
        if (r3 >= {1'b0, gtu_r}) begin
          rem_nxt = 2'(r3 - {1'b0, gtu_r});
          sum_nxt = {sum_r[SUM_W-2:0], 1'b1};
        end else begin
          rem_nxt = r3[1:0];
          sum_nxt = {sum_r[SUM_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r + 5'd1;
      end
      tas_pkg::S_OUT: begin
        if (out_free) begin
          if (take_best) begin
            best_seen_nxt = 1'b1;
            best_val_nxt = sum_r[tas_pkg::SCORE_W-1:0];
            best_arc_nxt = arc_cnt_r;
          end
          out_nxt.arc_number   = arc_cnt_r;
          out_nxt.arc_feasible = feas_r;
          out_nxt.arc_score    = sum_r[tas_pkg::SCORE_W-1:0];
          out_nxt.best_valid   = take_best || best_seen_r;
          out_nxt.best_arc     = take_best ? arc_cnt_r : best_arc_r;
          out_nxt.lead_score   = take_best ? sum_r[tas_pkg::SCORE_W-1:0] : best_val_r;
          out_valid_nxt = 1'b1;
          if (arc_cnt_r < ARC_LIMIT) arc_cnt_nxt = arc_cnt_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= tas_pkg::S_IDLE;
      arc_clear_r <= 1'b1;
      arc_cnt_r   <= '0;
      best_arc_r  <= '0;
      best_val_r  <= '0;
      best_seen_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      arc_clear_r <= arc_clear_nxt;
      arc_cnt_r   <= arc_cnt_nxt;
      best_arc_r  <= best_arc_nxt;
      best_val_r  <= best_val_nxt;
      best_seen_r <= best_seen_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ex_r <= ex_nxt;  ey_r <= ey_nxt;  feas_r <= feas_nxt;  g_r <= g_nxt;  m_r <= m_nxt;
    sum_r <= sum_nxt;  cnt_r <= cnt_nxt;  rem_r <= rem_nxt;  out_r <= out_nxt;
  end

  // An infeasible arc always reports a zero score.
  ap_infeasible_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.arc_feasible) |-> (out_r.arc_score == '0))
    else $error("infeasible arc reported a nonzero score");

  // The best score never falls below a feasible arc reported with it.
  ap_best_dominates: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.arc_feasible) |-> (out_r.best_valid &&
                                             out_r.lead_score >= out_r.arc_score))
    else $error("best score below a feasible arc score");

  // Without a feasible arc in the batch the best fields stay cleared.
  ap_best_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_r.best_valid) |-> (out_r.lead_score == '0 &&
                                            out_r.best_arc == '0))
    else $error("best fields set without a feasible arc");

  // The goal unit is only started with a goal index below the used count.
  ap_goal_index: assert property (@(posedge clk) disable iff (!rst_n)
    unit_start |-> (g_r < m_r))
    else $error("goal unit started beyond the used goals");

endmodule

// ===== rtl/core/tas_goal_unit.sv =====
// ----------------------------------------------------------------------------
// Goal term unit
// Computes 1 - sqrt(theta / 200) in Q1.16 for one endpoint and one goal,
// with bit-serial products, CORDIC vectoring and bit-serial divide and root.
// ----------------------------------------------------------------------------
module tas_goal_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [tas_pkg::COORD_W-1:0]  ex,
  input  logic signed [tas_pkg::COORD_W-1:0]  ey,
  input  logic signed [tas_pkg::COORD_W-1:0]  gx,
  input  logic signed [tas_pkg::COORD_W-1:0]  gy,
  output logic                                done,
  output logic [tas_pkg::TERM_W-1:0]          term
);

  localparam int PW = 50;
  localparam int RW = 52;
  localparam int QW = 37;

  tas_pkg::unit_state_t state_r, state_nxt;
  logic [5:0]                  cnt_r, cnt_nxt;
  logic [tas_pkg::COORD_W-1:0] ea_r, ea_nxt, eb_r, eb_nxt;
  logic signed [PW-1:0]        gxs_r, gxs_nxt, gys_r, gys_nxt;
  logic signed [PW-1:0]        dot_r, dot_nxt, crs_r, crs_nxt;
  logic signed [RW-1:0]        x_r, x_nxt, y_r, y_nxt;
  logic signed [tas_pkg::ANG_W-1:0] z_r, z_nxt;
  logic                        dneg_r, dneg_nxt;
  logic [QW-1:0]               dvd_r, dvd_nxt;
  logic [4:0]                  rem_r, rem_nxt;
  logic [17:0]                 sqr_r, sqr_nxt;
  logic [15:0]                 root_r, root_nxt;

  logic signed [PW-1:0]  px, py, qx, qy;
  logic signed [RW-1:0]  sx, sy;
  logic [5:0]            r6;
  logic [19:0]           s20, trial;
  logic signed [tas_pkg::ANG_W-1:0] zc;
  logic [tas_pkg::ANG_W-1:0] theta;
  logic                  zero_vec, done_mul, done_rot, done_div, done_sqrt, under_scale;

  function automatic logic signed [RW-1:0] sra0(input logic signed [RW-1:0] v,
                                                input logic [4:0] k);
    logic signed [RW-1:0] r;
    if (v < 0) begin
      r = -((-v) >>> k);
    end else begin
      r = v >>> k;
    end
    return r;
  endfunction

  assign zero_vec    = ((ex == '0) && (ey == '0)) || ((gx == '0) && (gy == '0));
  assign done_mul    = (cnt_r == 6'd23);
  assign done_rot    = (cnt_r == 6'd23);
  assign done_div    = (cnt_r == 6'(QW - 1));
  assign done_sqrt   = (cnt_r == 6'd15);
  assign under_scale = (x_r[RW-1:47] == '0) && (y_r[RW-1:47] == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      tas_pkg::U_IDLE: if (start) state_nxt = zero_vec ? tas_pkg::U_DIV : tas_pkg::U_MUL;
      tas_pkg::U_MUL:  if (done_mul) state_nxt = tas_pkg::U_NORM;
      tas_pkg::U_NORM: begin
        if (cnt_r == '0) begin
          if (dot_r == '0 && crs_r == '0) state_nxt = tas_pkg::U_DIV;
        end else if (!under_scale) begin
          state_nxt = tas_pkg::U_ROT;
        end
      end
      tas_pkg::U_ROT:  if (done_rot) state_nxt = tas_pkg::U_DIV;
      tas_pkg::U_DIV:  if (done_div) state_nxt = tas_pkg::U_SQRT;
      tas_pkg::U_SQRT: if (done_sqrt) state_nxt = tas_pkg::U_DONE;
      tas_pkg::U_DONE: state_nxt = tas_pkg::U_IDLE;
      default:         state_nxt = tas_pkg::U_IDLE;
    endcase
  end

  always_comb begin
    done = (state_r == tas_pkg::U_DONE);
    term = 17'd65536 - {1'b0, root_r};
  end

  always_comb begin
    cnt_nxt = cnt_r;  ea_nxt = ea_r;  eb_nxt = eb_r;
    gxs_nxt = gxs_r;  gys_nxt = gys_r;  dot_nxt = dot_r;  crs_nxt = crs_r;
    x_nxt = x_r;  y_nxt = y_r;  z_nxt = z_r;  dneg_nxt = dneg_r;
    dvd_nxt = dvd_r;  rem_nxt = rem_r;  sqr_nxt = sqr_r;  root_nxt = root_r;
    px = ea_r[0] ? gxs_r : '0;
    py = eb_r[0] ? gys_r : '0;
    qx = ea_r[0] ? gys_r : '0;
    qy = eb_r[0] ? gxs_r : '0;
    sx = sra0(x_r, cnt_r[4:0]);
    sy = sra0(y_r, cnt_r[4:0]);
    r6 = {rem_r, dvd_r[QW-1]};
    s20 = {sqr_r, dvd_r[31:30]};
    trial = {2'b00, root_r, 2'b01};
    zc = '0;
    theta = '0;
    unique case (state_r)
      tas_pkg::U_IDLE: begin
        cnt_nxt = '0;
        ea_nxt = ex;  eb_nxt = ey;
        gxs_nxt = PW'(gx);  gys_nxt = PW'(gy);
        dot_nxt = '0;  crs_nxt = '0;
        dvd_nxt = '0;  rem_nxt = '0;
      end
      tas_pkg::U_MUL: begin
        // The top bit of each endpoint coordinate carries negative weight.
        if (done_mul) begin
          dot_nxt = dot_r - (px + py);
          crs_nxt = crs_r - (qx - qy);
          cnt_nxt = '0;
        end else begin
          dot_nxt = dot_r + (px + py);
          crs_nxt = crs_r + (qx - qy);
          cnt_nxt = cnt_r + 6'd1;
        end
        ea_nxt = ea_r >> 1;
        eb_nxt = eb_r >> 1;
        gxs_nxt = gxs_r <<< 1;
        gys_nxt = gys_r <<< 1;
      end
      tas_pkg::U_NORM: begin
        if (cnt_r == '0) begin
          x_nxt = RW'(dot_r < 0 ? -dot_r : dot_r);
          y_nxt = RW'(crs_r < 0 ? -crs_r : crs_r);
          dneg_nxt = dot_r < 0;
          cnt_nxt = 6'd1;
        end else if (under_scale) begin
          x_nxt = x_r <<< 1;
          y_nxt = y_r <<< 1;
        end else begin
          cnt_nxt = '0;
          z_nxt = '0;
        end
      end
      tas_pkg::U_ROT: begin
        if (y_r >= 0) begin
          x_nxt = x_r + sy;
          y_nxt = y_r - sx;
          z_nxt = z_r + $signed(tas_pkg::atan_q16(cnt_r[4:0]));
        end else begin
          x_nxt = x_r - sy;
          y_nxt = y_r + sx;
          z_nxt = z_r - $signed(tas_pkg::atan_q16(cnt_r[4:0]));
        end
        if (z_nxt < 0) begin
          zc = '0;
        end else if (z_nxt > $signed(tas_pkg::DEG90)) begin
          zc = $signed(tas_pkg::DEG90);
        end else begin
          zc = z_nxt;
        end
        theta = dneg_r ? tas_pkg::DEG180 - $unsigned(zc) : $unsigned(zc);
        if (done_rot) begin
          cnt_nxt = '0;
          dvd_nxt = {theta[23:0], 13'd0};
          rem_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      tas_pkg::U_DIV: begin
        // theta * 65536 / 200 taken as (theta << 13) / 25, one bit a cycle.
        if (r6 >= 6'd25) begin
          rem_nxt = 5'(r6 - 6'd25);
          dvd_nxt = {dvd_r[QW-2:0], 1'b1};
        end else begin
          rem_nxt = r6[4:0];
          dvd_nxt = {dvd_r[QW-2:0], 1'b0};
        end
        if (done_div) begin
          cnt_nxt = '0;
          sqr_nxt = '0;
          root_nxt = '0;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      tas_pkg::U_SQRT: begin
        if (s20 >= trial) begin
          sqr_nxt = 18'(s20 - trial);
          root_nxt = {root_r[14:0], 1'b1};
        end else begin
          sqr_nxt = s20[17:0];
          root_nxt = {root_r[14:0], 1'b0};
        end
        dvd_nxt = dvd_r << 2;
        cnt_nxt = cnt_r + 6'd1;
      end
      tas_pkg::U_DONE: cnt_nxt = '0;
      default: cnt_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tas_pkg::U_IDLE;
      cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
    end
    ea_r <= ea_nxt;  eb_r <= eb_nxt;  gxs_r <= gxs_nxt;  gys_r <= gys_nxt;
    dot_r <= dot_nxt;  crs_r <= crs_nxt;  x_r <= x_nxt;  y_r <= y_nxt;
    z_r <= z_nxt;  dneg_r <= dneg_nxt;  dvd_r <= dvd_nxt;  rem_r <= rem_nxt;
    sqr_r <= sqr_nxt;  root_r <= root_nxt;
  end

  ap_term_range: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> (term <= 17'd65536 && term != '0))
    else $error("goal term out of range");

  ap_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> !done)
    else $error("goal unit done held for more than one cycle");

  ap_root_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == tas_pkg::U_SQRT) |-> (root_r[15] == 1'b0 || cnt_r == 6'd0))
    else $error("square root grew beyond its range");

endmodule
